[sv/spmd_pkg.sv]
`default_nettype none
package spmd_pkg;
    localparam int CFG_BITS   = 7;
    localparam int DELAY_BITS = 22;
    localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

    typedef enum logic [0:0] {
        REG_NODE_COUNT  = 1'b0,
        REG_SOURCE_NODE = 1'b1
    } t_reg_idx;

    // classified word passed from front to back
    typedef struct packed {
        logic       store;
        logic       bad;
        logic [6:0] from_node;
        logic [6:0] to_node;
        logic [15:0] weight;
        logic       last;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_END,
        ST_EDGE_RD,
        ST_EDGE_DR,
        ST_EDGE_DO,
        ST_FIN,
        ST_FIN_END,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

[sv/spmd_front.sv]
`default_nettype none
module spmd_front #(
    parameter int MAX_NODES = 64
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    output logic             o_ready,
    input  wire              i_edge_valid,
    input  wire  [6:0]       i_from_node,
    input  wire  [6:0]       i_to_node,
    input  wire  [15:0]      i_weight,
    input  wire              i_last,
    input  wire  [6:0]       i_node_count,
    output logic             o_cmd_valid,
    input  wire              i_cmd_ready,
    output spmd_pkg::t_cmd   o_cmd
);
    localparam int QD = 2;
    localparam int NB = $clog2(MAX_NODES + 1) > 7 ? $clog2(MAX_NODES + 1) : 7;

    spmd_pkg::t_cmd r_q [QD];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic [NB-1:0]  w_n;
    logic [NB-1:0]  w_from, w_to;
    logic           w_bad, w_push, w_pop;
    spmd_pkg::t_cmd w_cmd;

    always_comb begin
        w_from = NB'(i_from_node);
        w_to   = NB'(i_to_node);
        if (i_node_count == 7'd0) begin
            w_n = NB'(1);
        end else if (NB'(i_node_count) > NB'(MAX_NODES)) begin
            w_n = NB'(MAX_NODES);
        end else begin
            w_n = NB'(i_node_count);
        end
        w_bad = (w_from == '0) || (w_from > w_n) || (w_to == '0) || (w_to > w_n);
        w_cmd.store     = i_edge_valid && !w_bad;
        w_cmd.bad       = i_edge_valid && w_bad;
        w_cmd.from_node = i_from_node;
        w_cmd.to_node   = i_to_node;
        w_cmd.weight    = i_weight;
        w_cmd.last      = i_last;
    end

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule
`default_nettype wire

[sv/spmd_back.sv]
`default_nettype none
module spmd_back #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cmd_valid,
    output logic                 o_cmd_ready,
    input  spmd_pkg::t_cmd       i_cmd,
    input  wire  [6:0]           i_node_count,
    input  wire  [6:0]           i_source_node,
    output logic                 o_valid,
    input  wire                  i_ready,
    output logic [21:0]          o_max_delay,
    output logic                 o_unreachable,
    output logic                 o_label_error
);
    localparam int NI = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NB = $clog2(MAX_NODES + 1) > 7 ? $clog2(MAX_NODES + 1) : 7;
    localparam int EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC = $clog2(MAX_EDGES + 1);
    localparam int DB = WEIGHT_BITS + $clog2(MAX_NODES + 1) + 1;
    localparam int ED = 2 * NB + WEIGHT_BITS;

    // edge memory and distance memory
    logic [ED-1:0] r_emem [MAX_EDGES];
    logic [DB-1:0] r_dmem [MAX_NODES];
    logic [MAX_NODES-1:0] r_reached, r_settled;

    spmd_pkg::t_state r_st, n_st;
    logic [EC-1:0] r_etot;
    logic          r_err;
    logic [NB-1:0] r_n;
    logic [NB:0]   r_i, r_round;
    logic [EC-1:0] r_e;
    logic          r_found;
    logic [NI-1:0] r_u;
    logic [DB-1:0] r_best, r_du;
    logic [ED-1:0] r_erd;
    logic [DB-1:0] r_drd;
    logic          r_all;
    logic [21:0]   r_max;
    logic          r_unr, r_lerr;

    logic [NB-1:0] w_n, w_src;
    logic          w_src_ok;
    logic [NI-1:0] w_i, w_t, w_ra;
    logic [NB-1:0] w_ef, w_et;
    logic [DB-1:0] w_nd;
    logic          w_relax;

    always_comb begin
        if (i_node_count == 7'd0) w_n = NB'(1);
        else if (NB'(i_node_count) > NB'(MAX_NODES)) w_n = NB'(MAX_NODES);
        else w_n = NB'(i_node_count);
        w_src    = NB'(i_source_node);
        w_src_ok = (w_src != '0) && (w_src <= w_n);
        w_i   = r_i[NI-1:0];
        w_ef  = r_erd[ED-1 -: NB];
        w_et  = r_erd[ED-NB-1 -: NB];
        w_t   = NI'(w_et - NB'(1));
        w_nd  = r_du + DB'(r_erd[WEIGHT_BITS-1:0]);
        w_relax = (w_ef == NB'(r_u) + NB'(1)) && (w_et != '0) && (w_et <= r_n)
                  && (!r_reached[w_t] || (w_nd < r_drd));
        // distance read address: the edge target, or during scan and finish one node ahead of the one examined
        if (r_st == spmd_pkg::ST_EDGE_DR) begin
            w_ra = w_t;
        end else if (r_st == spmd_pkg::ST_SCAN || r_st == spmd_pkg::ST_FIN) begin
            w_ra = NI'(r_i + 1'b1);
        end else begin
            w_ra = '0;
        end
    end

    assign o_cmd_ready   = (r_st == spmd_pkg::ST_IDLE);
    assign o_valid       = (r_st == spmd_pkg::ST_OUT);
    assign o_max_delay   = r_max;
    assign o_unreachable = r_unr;
    assign o_label_error = r_lerr;

    always_comb begin
        n_st = r_st;
        case (r_st)
            spmd_pkg::ST_IDLE:
                if (i_cmd_valid && i_cmd.last) n_st = spmd_pkg::ST_INIT;
            spmd_pkg::ST_INIT:
                n_st = w_src_ok ? spmd_pkg::ST_SCAN : spmd_pkg::ST_FIN_END;
            spmd_pkg::ST_SCAN:
                if (r_i == {1'b0, r_n} - 1'b1) n_st = spmd_pkg::ST_SCAN_END;
            spmd_pkg::ST_SCAN_END:
                n_st = r_found ? ((r_etot == '0) ? spmd_pkg::ST_SCAN
                                                 : spmd_pkg::ST_EDGE_RD)
                               : spmd_pkg::ST_FIN;
            spmd_pkg::ST_EDGE_RD:
                n_st = spmd_pkg::ST_EDGE_DR;
            spmd_pkg::ST_EDGE_DR:
                n_st = spmd_pkg::ST_EDGE_DO;
            spmd_pkg::ST_EDGE_DO:
                if (r_e == r_etot) begin
                    n_st = (r_round == {1'b0, r_n}) ? spmd_pkg::ST_FIN
                                                    : spmd_pkg::ST_SCAN;
                end else begin
                    n_st = spmd_pkg::ST_EDGE_RD;
                end
            spmd_pkg::ST_FIN:
                if (r_i == {1'b0, r_n}) n_st = spmd_pkg::ST_FIN_END;
            spmd_pkg::ST_FIN_END:
                n_st = spmd_pkg::ST_OUT;
            spmd_pkg::ST_OUT:
                if (i_ready) n_st = spmd_pkg::ST_IDLE;
            default:
                n_st = spmd_pkg::ST_IDLE;
        endcase
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        if (r_st == spmd_pkg::ST_IDLE && i_cmd_valid && i_cmd.store
            && r_etot < EC'(MAX_EDGES)) begin
            r_emem[r_etot[EI-1:0]] <= {NB'(i_cmd.from_node), NB'(i_cmd.to_node),
                                       WEIGHT_BITS'(i_cmd.weight)};
        end
        if (r_st == spmd_pkg::ST_EDGE_RD) begin
            r_erd <= r_emem[r_e[EI-1:0]];
        end
        // source distance set as the last word is taken
        if (r_st == spmd_pkg::ST_IDLE && i_cmd_valid && i_cmd.last && w_src_ok) begin
            r_dmem[NI'(w_src - NB'(1))] <= '0;
        end else if (r_st == spmd_pkg::ST_EDGE_DO && r_e != r_etot && w_relax) begin
            r_dmem[w_t] <= w_nd;
        end
        r_drd <= r_dmem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= spmd_pkg::ST_IDLE;
            r_etot    <= '0;
            r_err     <= 1'b0;
            r_reached <= '0;
            r_settled <= '0;
        end else begin
            r_st <= n_st;
            case (r_st)
                spmd_pkg::ST_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.bad) r_err <= 1'b1;
                        if (i_cmd.store && r_etot < EC'(MAX_EDGES))
                            r_etot <= r_etot + EC'(1);
                    end
                    r_n     <= w_n;
                    r_lerr  <= r_err || (i_cmd_valid && i_cmd.bad);
                    r_round <= '0;
                end
                spmd_pkg::ST_INIT: begin
                    r_reached <= w_src_ok ? (MAX_NODES'(1) << (w_src - NB'(1))) : '0;
                    r_settled <= '0;
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_all   <= 1'b0;
                    r_best  <= '0;
                end
                spmd_pkg::ST_SCAN: begin
                    // r_drd holds distance of node r_i
                    if (r_reached[w_i] && !r_settled[w_i] &&
                        (!r_found || r_drd < r_best)) begin
                        r_found <= 1'b1;
                        r_u     <= w_i;
                        r_best  <= r_drd;
                    end
                    r_i <= r_i + 1'b1;
                end
                spmd_pkg::ST_SCAN_END: begin
                    if (r_found) begin
                        r_settled[r_u] <= 1'b1;
                        r_du    <= r_best;
                        r_round <= r_round + 1'b1;
                    end
                    r_e     <= '0;
                    r_i     <= '0;
                    r_found <= 1'b0;
                    r_best  <= '0;
                    r_all   <= 1'b1;
                end
                spmd_pkg::ST_EDGE_RD: ;
                spmd_pkg::ST_EDGE_DR: ;
                spmd_pkg::ST_EDGE_DO: begin
                    if (r_e != r_etot) begin
                        if (w_relax) r_reached[w_t] <= 1'b1;
                        r_e <= r_e + EC'(1);
                    end
                    r_i <= '0;
                end
                spmd_pkg::ST_FIN: begin
                    if (r_i != {1'b0, r_n}) begin
                        if (!r_reached[w_i]) r_all <= 1'b0;
                        else if (r_drd > r_best) r_best <= r_drd;
                        r_i <= r_i + 1'b1;
                    end
                end
                spmd_pkg::ST_FIN_END: begin
                    r_unr <= !r_all;
                    if (!r_all) r_max <= '0;
                    else if (r_best > DB'(spmd_pkg::DELAY_MAX)) r_max <= spmd_pkg::DELAY_MAX;
                    else r_max <= r_best[21:0];
                    r_etot <= '0;
                    r_err  <= 1'b0;
                end
                spmd_pkg::ST_OUT: ;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

[sv/shortest_path_max_delay.sv]
`default_nettype none
// channel  | signals                                      | direction
// config   | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
// edge in  | i_valid/o_ready, edge_valid, from, to, weight, last | in
// result   | o_valid/i_ready, max_delay, unreachable, label_error | out
// an edge word passes through the front queue into the back store
// the last word runs the search: per settled node a scan of all nodes and a settle step,
// then per stored edge an edge read, a distance read and a relax step, plus one closing round
// a maximum pass over the nodes follows, then a finish step and the result word
// synchronous active-low reset empties the store and clears flags
// the two-entry queue holds up to two words while the back is busy
module shortest_path_max_delay #(
    parameter int MAX_NODES   = 64,
    parameter int MAX_EDGES   = 256,
    parameter int WEIGHT_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [6:0]  i_cfg_data,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_edge_valid,
    input  wire  [6:0]  i_from_node,
    input  wire  [6:0]  i_to_node,
    input  wire  [15:0] i_weight,
    input  wire         i_last,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [21:0] o_max_delay,
    output logic        o_unreachable,
    output logic        o_label_error
);
    logic [6:0]     r_node_count, r_source_node;
    logic           w_cmd_valid, w_cmd_ready;
    spmd_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count  <= 7'd1;
            r_source_node <= 7'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                spmd_pkg::REG_NODE_COUNT:  r_node_count  <= i_cfg_data;
                spmd_pkg::REG_SOURCE_NODE: r_source_node <= i_cfg_data;
                default: ;
            endcase
        end
    end

    spmd_front #(.MAX_NODES(MAX_NODES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_edge_valid (i_edge_valid),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .i_weight     (i_weight),
        .i_last       (i_last),
        .i_node_count (r_node_count),
        .o_cmd_valid  (w_cmd_valid),
        .i_cmd_ready  (w_cmd_ready),
        .o_cmd        (w_cmd)
    );

    spmd_back #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .o_cmd_ready   (w_cmd_ready),
        .i_cmd         (w_cmd),
        .i_node_count  (r_node_count),
        .i_source_node (r_source_node),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_max_delay   (o_max_delay),
        .o_unreachable (o_unreachable),
        .o_label_error (o_label_error)
    );
endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_CAP = 64;
    localparam int EDGES_CAP = 256;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;
    logic        i_valid = 1'b0;
    wire         o_ready;
    logic        i_edge_valid = 1'b0;
    logic [6:0]  i_from_node = '0;
    logic [6:0]  i_to_node = '0;
    logic [15:0] i_weight = '0;
    logic        i_last = 1'b0;
    wire         o_valid;
    logic        i_ready = 1'b0;
    wire  [21:0] o_max_delay;
    wire         o_unreachable;
    wire         o_label_error;

    shortest_path_max_delay dut (.*);

    always #6 i_clk = ~i_clk;

    // one expected answer per finished graph
    typedef struct packed {
        logic [21:0] max_delay;
        logic        unreachable;
        logic        label_error;
    } t_answer;

    t_answer     answer_q[$];
    int          fail_count = 0;
    bit          calm = 1'b0;   // no idling in the closing part

    // predictor state
    logic [6:0]  node_reg;
    logic [6:0]  src_reg;
    logic [6:0]  path_from[EDGES_CAP];
    logic [6:0]  path_to[EDGES_CAP];
    logic [15:0] path_w[EDGES_CAP];
    int          path_total;
    bit          bad_label;

    function automatic int eff_nodes();
        if (node_reg < 1) return 1;
        if (node_reg > NODES_CAP) return NODES_CAP;
        return int'(node_reg);
    endfunction

    // linear-scan search over the stored edges
    function automatic t_answer solve_graph();
        int      n;
        int      u;
        bit      found;
        bit      all_reached;
        longint  dist_tab[NODES_CAP];
        bit      reached[NODES_CAP];
        bit      done[NODES_CAP];
        longint  nd;
        longint  best;
        t_answer a;
        n = eff_nodes();
        best = 0;
        all_reached = 1'b1;
        for (int i = 0; i < NODES_CAP; i++) begin
            dist_tab[i] = 0; reached[i] = 0; done[i] = 0;
        end
        if (src_reg < 1 || src_reg > n) begin
            all_reached = 1'b0;
        end else begin
            reached[src_reg-1] = 1'b1;
            for (int r = 0; r < n; r++) begin
                found = 1'b0;
                u = 0;
                for (int i = 0; i < n; i++)
                    if (reached[i] && !done[i] && (!found || dist_tab[i] < dist_tab[u])) begin
                        u = i;
                        found = 1'b1;
                    end
                if (!found) break;
                done[u] = 1'b1;
                for (int e = 0; e < path_total; e++) begin
                    if (path_from[e] != u + 1 || path_to[e] < 1 || path_to[e] > n) continue;
                    nd = dist_tab[u] + path_w[e];
                    if (!reached[path_to[e]-1] || nd < dist_tab[path_to[e]-1]) begin
                        reached[path_to[e]-1] = 1'b1;
                        dist_tab[path_to[e]-1] = nd;
                    end
                end
            end
            for (int i = 0; i < n; i++) begin
                if (!reached[i]) all_reached = 1'b0;
                else if (dist_tab[i] > best) best = dist_tab[i];
            end
        end
        if (!all_reached) best = 0;
        if (best > spmd_pkg::DELAY_MAX) best = spmd_pkg::DELAY_MAX;
        a.max_delay = best[21:0];
        a.unreachable = !all_reached;
        a.label_error = bad_label;
        return a;
    endfunction

    function automatic void predict_word(bit ev, logic [6:0] f, logic [6:0] t,
                                         logic [15:0] w, bit lst);
        int n;
        n = eff_nodes();
        if (ev) begin
            if (f < 1 || f > n || t < 1 || t > n) bad_label = 1'b1;
            else if (path_total < EDGES_CAP) begin
                path_from[path_total] = f;
                path_to[path_total] = t;
                path_w[path_total] = w;
                path_total++;
            end
        end
        if (lst) begin
            answer_q.push_back(solve_graph());
            path_total = 0;
            bad_label = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // valid drops only when the input side idles
    task automatic idle_gap();
        if (!calm && $urandom_range(3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
    endtask

    // sends one edge word and, once it is accepted, predicts its effect
    task automatic send_word(bit ev, logic [6:0] f, logic [6:0] t,
                             logic [15:0] w, bit lst);
        idle_gap();
        i_valid <= 1'b1;
        i_edge_valid <= ev;
        i_from_node <= f;
        i_to_node <= t;
        i_weight <= w;
        i_last <= lst;
        do @(posedge i_clk); while (!o_ready);
        predict_word(ev, f, t, w, lst);
        @(negedge i_clk);
    endtask

    // register writes only once the block has drained
    task automatic write_reg(spmd_pkg::t_reg_idx idx, logic [6:0] val);
        i_valid <= 1'b0;
        wait (answer_q.size() == 0);
        repeat (20) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == spmd_pkg::REG_NODE_COUNT) node_reg = val;
        else src_reg = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result side: random back-pressure, compare against oldest answer
    always @(negedge i_clk) begin
        if (!calm && $urandom_range(4) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(4, 1) - 1) @(negedge i_clk);
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                report_mismatch("unexpected word", o_max_delay, -1);
            end else begin
                want = answer_q.pop_front();
                if (o_max_delay !== want.max_delay)
                    report_mismatch("max_delay", o_max_delay, want.max_delay);
                if (o_unreachable !== want.unreachable)
                    report_mismatch("unreachable", o_unreachable, want.unreachable);
                if (o_label_error !== want.label_error)
                    report_mismatch("label_error", o_label_error, want.label_error);
            end
        end
    end

    // random graph of given size, mostly well labelled
    task automatic send_graph(int edges, int noise);
        int n;
        n = eff_nodes();
        for (int e = 0; e < edges; e++) begin
            if ($urandom_range(99) < noise)
                send_word(1'($urandom_range(1)), 7'($urandom_range(127)),
                          7'($urandom_range(127)), 16'($urandom), 1'b0);
            else
                send_word(1'b1, 7'($urandom_range(n, 1)), 7'($urandom_range(n, 1)),
                          ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom),
                          1'b0);
        end
        if ($urandom_range(1))
            send_word(1'b0, 7'($urandom), 7'($urandom), 16'($urandom), 1'b1);
        else
            send_word(1'b1, 7'($urandom_range(n, 1)), 7'($urandom_range(n, 1)),
                      16'($urandom), 1'b1);
    endtask

    task automatic test_directed();
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd1);
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd1);
        send_word(1'b0, 7'd0, 7'd0, 16'd0, 1'b1);           // single node
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd4);
        send_word(1'b1, 7'd1, 7'd2, 16'hFFFF, 1'b0);
        send_word(1'b1, 7'd2, 7'd3, 16'hFFFF, 1'b0);
        send_word(1'b0, 7'h7F, 7'h7F, 16'hFFFF, 1'b0);      // empty, no effect
        send_word(1'b1, 7'd3, 7'd4, 16'd0, 1'b0);
        send_word(1'b1, 7'd1, 7'd4, 16'd5, 1'b1);
        send_word(1'b1, 7'd0, 7'd2, 16'd1, 1'b0);           // bad label
        send_word(1'b1, 7'd1, 7'd5, 16'd1, 1'b0);           // beyond count
        send_word(1'b1, 7'd1, 7'd2, 16'd1, 1'b1);           // unreachable too
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd0);         // source outside
        send_word(1'b1, 7'd1, 7'd2, 16'd1, 1'b1);
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd5);
        send_word(1'b0, 7'd0, 7'd0, 16'd0, 1'b1);
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd0);          // treated as one
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd1);
        send_word(1'b1, 7'd1, 7'd1, 16'd3, 1'b1);
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd127);        // clamped to max
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd64);
        for (int i = 64; i > 1; i--)
            send_word(1'b1, 7'(i), 7'(i - 1), 16'hFFFF, 1'b0);
        send_word(1'b1, 7'd1, 7'd64, 16'd0, 1'b1);          // longest chain
    endtask

    task automatic test_shrunk_count();
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd8);
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd1);
        for (int i = 1; i < 8; i++)
            send_word(1'b1, 7'(i), 7'(i + 1), 16'(i), 1'b0);
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd4);          // stored edges beyond ignored
        send_word(1'b0, 7'd0, 7'd0, 16'd0, 1'b1);
    endtask

    task automatic test_store_full();
        write_reg(spmd_pkg::REG_NODE_COUNT, 7'd16);
        write_reg(spmd_pkg::REG_SOURCE_NODE, 7'd3);
        send_graph(EDGES_CAP + 20, 0);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1500) begin
            int edges;
            write_reg(spmd_pkg::REG_NODE_COUNT,
                      7'(($urandom_range(9) == 0) ? $urandom_range(64, 1)
                                                  : $urandom_range(10, 1)));
            write_reg(spmd_pkg::REG_SOURCE_NODE,
                      7'(($urandom_range(9) == 0) ? $urandom_range(127)
                                                  : $urandom_range(node_reg, 1)));
            repeat ($urandom_range(6, 2)) begin
                edges = ($urandom_range(19) == 0) ? $urandom_range(120)
                                                  : $urandom_range(20);
                send_graph(edges, 8);
                sent += edges + 1;
                if (sent > 1300) calm = 1'b1;
            end
        end
    endtask

    initial begin
        node_reg = 7'd1;
        src_reg = 7'd1;
        path_total = 0;
        bad_label = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_shrunk_count();
        test_store_full();
        test_random();
        i_valid <= 1'b0;
        wait (answer_q.size() == 0);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) $display("[shortest_path_max_delay] OK");
        else $display("[shortest_path_max_delay] ERROR");
        $finish;
    end

    initial begin
        #200ms;
        $display("[shortest_path_max_delay] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

[shortest_path_max_delay.f]
sv/spmd_pkg.sv
sv/spmd_front.sv
sv/spmd_back.sv
sv/shortest_path_max_delay.sv
test/tb_top.sv
